>>> design/cfq_pkg.sv
package cfq_pkg;

   localparam int DEPTH_DEFAULT      = 16;
   localparam int DATA_WIDTH_DEFAULT = 32;

   // Fixed field widths of the ports
   localparam int OP_W    = 2;
   localparam int WORD_W  = 32;
   localparam int STAT_W  = 2;
   localparam int CAP_W   = 5;
   localparam int CAP_RESET = 16;

   localparam logic [OP_W-1:0] OP_ENQUEUE = 2'd0;
   localparam logic [OP_W-1:0] OP_DEQUEUE = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR   = 2'd2;
   localparam logic [OP_W-1:0] OP_QUERY   = 2'd3;

   localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
   localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

   typedef struct packed {
      logic              load;
      logic              enq_ok;
      logic              deq_ok;
      logic              clr;
      logic [STAT_W-1:0] status;
   } cfq_cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
   } cfq_stat_type;

endpackage

>>> design/cfq_ctrl.sv
module cfq_ctrl
   import cfq_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  logic [OP_W-1:0] req_opcode,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   input  cfq_stat_type    stat,
   output cfq_cmd_type     cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_HOLD = 1'b1;

   logic state_ff, state_in;
   logic accept;

   // Take a new word whenever the result register is free or drains this cycle
   assign req_stall = (state_ff == ST_HOLD) && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = (state_ff == ST_HOLD);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_HOLD;
         end
         ST_HOLD: begin
            if (!rsp_stall && !accept) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      cmd.load   = accept;
      cmd.status = STAT_OK;
      unique case (req_opcode)
         OP_ENQUEUE: begin
            if (stat.full) cmd.status = STAT_FULL;
            else           cmd.enq_ok = accept;
         end
         OP_DEQUEUE: begin
            if (stat.empty) cmd.status = STAT_EMPTY;
            else            cmd.deq_ok = accept;
         end
         OP_CLEAR: begin
            cmd.clr = accept;
         end
         OP_QUERY: begin
            cmd.status = STAT_OK;
         end
         default: cmd.status = STAT_OK;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

endmodule

>>> design/cfq_datapath.sv
module cfq_datapath
   import cfq_pkg::*;
#(
   parameter int DEPTH      = DEPTH_DEFAULT,
   parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
)(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [CAP_W-1:0]  csr_wr_data,
   input  logic [WORD_W-1:0] req_push_value,
   input  cfq_cmd_type       cmd,
   output cfq_stat_type      stat,
   output logic [STAT_W-1:0] rsp_status,
   output logic [WORD_W-1:0] rsp_pop_value,
   output logic              rsp_is_empty,
   output logic              rsp_is_full,
   output logic [CAP_W-1:0]  rsp_occupancy
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = (PW + 1 > CAP_W) ? PW + 1 : CAP_W;
   localparam logic [CAP_W-1:0] CAP_RST =
      CAP_W'((CAP_RESET > DEPTH) ? DEPTH : CAP_RESET);

   logic [DATA_WIDTH-1:0] mem [DEPTH];

   logic [PW-1:0]         head_ff, head_in;
   logic [PW-1:0]         tail_ff, tail_in;
   logic [CAP_W-1:0]      count_ff, count_in;
   logic [CAP_W-1:0]      cap_ff, cap_in;
   logic [DATA_WIDTH-1:0] rd_data_ff;
   logic                  pop_ok_ff;
   logic [STAT_W-1:0]     status_ff;
   logic                  empty_ff, full_ff;
   logic [PW-1:0]         head_next, tail_next;

   // Step a pointer by one, back to zero at or past the capacity
   function automatic logic [PW-1:0] advance(input logic [PW-1:0] ptr,
                                             input logic [CAP_W-1:0] cap);
      logic [CW-1:0] nxt;
      nxt = CW'(ptr) + CW'(1);
      if (nxt >= CW'(cap)) return '0;
      return nxt[PW-1:0];
   endfunction

   assign head_next = advance(head_ff, cap_ff);
   assign tail_next = advance(tail_ff, cap_ff);

   assign stat.empty = (count_ff == '0);
   assign stat.full  = (count_ff >= cap_ff);

   always_comb begin
      if (csr_wr_data == '0)
         cap_in = CAP_W'(1);
      else if (CW'(csr_wr_data) > CW'(DEPTH))
         cap_in = CAP_W'(DEPTH);
      else
         cap_in = csr_wr_data;
   end

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (cmd.clr) begin
         head_in  = '0;
         tail_in  = '0;
         count_in = '0;
      end else if (cmd.enq_ok) begin
         tail_in  = tail_next;
         count_in = count_ff + CAP_W'(1);
      end else if (cmd.deq_ok) begin
         head_in  = head_next;
         count_in = count_ff - CAP_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
         cap_ff   <= CAP_RST;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
         if (csr_wr_en) cap_ff <= cap_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.enq_ok) mem[tail_next] <= DATA_WIDTH'(req_push_value);
      if (cmd.deq_ok) rd_data_ff <= mem[head_next];
   end

   // Result payload, held while the word waits downstream
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         status_ff <= cmd.status;
         pop_ok_ff <= cmd.deq_ok;
         empty_ff  <= (count_in == '0);
         full_ff   <= (count_in >= cap_ff);
      end
   end

   assign rsp_status    = status_ff;
   assign rsp_pop_value = pop_ok_ff ? WORD_W'(rd_data_ff) : '0;
   assign rsp_is_empty  = empty_ff;
   assign rsp_is_full   = full_ff;
   assign rsp_occupancy = count_ff;

`ifndef NO_ASSERTIONS
   a_clear_zeroes: assert property (@(posedge clock) disable iff (reset)
      cmd.clr |=> (count_ff == '0) && (head_ff == '0) && (tail_ff == '0))
      else $error("clear left pointers or count nonzero");

   a_enq_count: assert property (@(posedge clock) disable iff (reset)
      cmd.enq_ok |=> count_ff == $past(count_ff) + CAP_W'(1))
      else $error("enqueue did not raise the count by one");

   a_deq_count: assert property (@(posedge clock) disable iff (reset)
      cmd.deq_ok |=> count_ff == $past(count_ff) - CAP_W'(1))
      else $error("dequeue did not lower the count by one");

   a_idle_stable: assert property (@(posedge clock) disable iff (reset)
      !cmd.load |=> $stable(count_ff) && $stable(head_ff) && $stable(tail_ff))
      else $error("queue state moved without an accepted word");

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> rsp_is_empty == (count_ff == '0))
      else $error("empty flag disagrees with count");
`endif

endmodule

>>> design/circular_fifo_queue_core.sv
// Channel   Handshake             Payload
// req       req_valid/req_stall   req_opcode, req_push_value
// rsp       rsp_valid/rsp_stall   rsp_status, rsp_pop_value, rsp_is_empty,
//                                 rsp_is_full, rsp_occupancy
// csr       csr_wr_en             csr_wr_data (capacity in use)
//
// One word per cycle; a result appears the cycle after its request is taken.
// The single result register sets the rate: a new request is taken in the
// cycle the held result drains, and req_stall follows rsp_stall while full.
// Synchronous active-high reset clears pointers and count; capacity resets
// to 16 (clamped to DEPTH). Store contents are undefined until written.
module circular_fifo_queue_core
   import cfq_pkg::*;
#(
   parameter int DEPTH      = DEPTH_DEFAULT,
   parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
)(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [CAP_W-1:0]  csr_wr_data,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [OP_W-1:0]   req_opcode,
   input  logic [WORD_W-1:0] req_push_value,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [STAT_W-1:0] rsp_status,
   output logic [WORD_W-1:0] rsp_pop_value,
   output logic              rsp_is_empty,
   output logic              rsp_is_full,
   output logic [CAP_W-1:0]  rsp_occupancy
);

   cfq_cmd_type  cmd;
   cfq_stat_type stat;

   cfq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_opcode (req_opcode),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .stat       (stat),
      .cmd        (cmd)
   );

   cfq_datapath #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_push_value (req_push_value),
      .cmd            (cmd),
      .stat           (stat),
      .rsp_status     (rsp_status),
      .rsp_pop_value  (rsp_pop_value),
      .rsp_is_empty   (rsp_is_empty),
      .rsp_is_full    (rsp_is_full),
      .rsp_occupancy  (rsp_occupancy)
   );

endmodule

>>> dv/circular_fifo_queue_core_tb.sv
`timescale 1ns / 100ps

module circular_fifo_queue_core_tb;
   import cfq_pkg::*;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [WORD_W-1:0] pop_value;
      logic              is_empty;
      logic              is_full;
      logic [CAP_W-1:0]  occupancy;
   } reply_type;

   // Ring model of the queue plus the replies it still owes.
   class reply_tracker_type;
      int unsigned       cap_reg;
      int unsigned       head, tail, count;
      logic [WORD_W-1:0] slots [DEPTH_DEFAULT];
      bit                written [DEPTH_DEFAULT];
      reply_type         replies_due[$];
      int                errors, checked, requests, refused, underflows, clears;

      function new();
         cap_reg = CAP_RESET;
         head = 0;
         tail = 0;
         count = 0;
         foreach (written[i]) written[i] = 1'b0;
      endfunction

      // Clamp the register to 1..DEPTH.
      function int unsigned usable();
         if (cap_reg < 1) return 1;
         if (cap_reg > DEPTH_DEFAULT) return DEPTH_DEFAULT;
         return cap_reg;
      endfunction

      function int unsigned step_ptr(int unsigned p);
         int unsigned n;
         n = p + 1;
         if (n >= usable()) n = 0;
         return n;
      endfunction

      function void set_capacity(int unsigned v);
         cap_reg = v;
      endfunction

      function bit reads_unwritten(logic [OP_W-1:0] op);
         return op == OP_DEQUEUE && count != 0 && !written[step_ptr(head)];
      endfunction

      function int outstanding();
         return replies_due.size();
      endfunction

      function void note_request(logic [OP_W-1:0] op, logic [WORD_W-1:0] v);
         reply_type r;
         r = '0;
         requests++;
         case (op)
            OP_ENQUEUE: begin
               if (count >= usable()) begin
                  r.status = STAT_FULL;
                  refused++;
               end else begin
                  count++;
                  tail = step_ptr(tail);
                  slots[tail] = v;
                  written[tail] = 1'b1;
               end
            end
            OP_DEQUEUE: begin
               if (count == 0) begin
                  r.status = STAT_EMPTY;
                  underflows++;
               end else begin
                  count--;
                  head = step_ptr(head);
                  r.pop_value = slots[head];
               end
            end
            OP_CLEAR: begin
               count = 0;
               head = 0;
               tail = 0;
               clears++;
            end
            default: ;
         endcase
         r.is_empty = (count == 0);
         r.is_full = (count >= usable());
         r.occupancy = count[CAP_W-1:0];
         replies_due.push_back(r);
      endfunction

      function void compare(string field, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
         if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %h actual %h", $time, field, want, got);
         end
      endfunction

      function void check_reply(reply_type got);
         reply_type want;
         if (replies_due.size() == 0) begin
            errors++;
            $display("%0t: reply with nothing pending, actual %h", $time, got);
            return;
         end
         want = replies_due.pop_front();
         checked++;
         compare("status", want.status, got.status);
         compare("pop_value", want.pop_value, got.pop_value);
         compare("is_empty", want.is_empty, got.is_empty);
         compare("is_full", want.is_full, got.is_full);
         compare("occupancy", want.occupancy, got.occupancy);
      endfunction
   endclass

   logic              clock;
   logic              reset = 1'b1;
   logic              csr_wr_en = 1'b0;
   logic [CAP_W-1:0]  csr_wr_data = '0;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [OP_W-1:0]   req_opcode = OP_QUERY;
   logic [WORD_W-1:0] req_push_value = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [STAT_W-1:0] rsp_status;
   logic [WORD_W-1:0] rsp_pop_value;
   logic              rsp_is_empty;
   logic              rsp_is_full;
   logic [CAP_W-1:0]  rsp_occupancy;

   int idle_pct = 0;
   int stall_pct = 0;

   reply_tracker_type tracker = new();

   circular_fifo_queue_core DUT (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_opcode     (req_opcode),
      .req_push_value (req_push_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_pop_value  (rsp_pop_value),
      .rsp_is_empty   (rsp_is_empty),
      .rsp_is_full    (rsp_is_full),
      .rsp_occupancy  (rsp_occupancy)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("circular_fifo_queue_core test failed");
      $finish;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         tracker.check_reply({rsp_status, rsp_pop_value, rsp_is_empty, rsp_is_full,
                              rsp_occupancy});
   end

   // Hold the word until it is taken, then update the ring model.
   task automatic send_word(input logic [OP_W-1:0] op, input logic [WORD_W-1:0] v);
      // never pop a slot that has not been written since reset
      if (tracker.reads_unwritten(op)) op = OP_QUERY;
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_push_value <= v;
      do @(posedge clock); while (req_stall);
      tracker.note_request(op, v);
   endtask

   task automatic drain();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      while (tracker.outstanding() > 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [CAP_W-1:0] v);
      drain();
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      tracker.set_capacity(v);
   endtask

   task automatic run_phase(input int n, input logic [CAP_W-1:0] cap, input int gap,
                            input int stall, input bit clear_first);
      int i, r, bias, run_left;
      logic [OP_W-1:0] op;
      write_capacity(cap);
      idle_pct = gap;
      stall_pct = stall;
      if (clear_first) send_word(OP_CLEAR, $urandom());
      bias = 80;
      run_left = 0;
      for (i = 0; i < n; i++) begin
         // alternate fill and drain runs so both full and empty get hit
         if (run_left == 0) begin
            bias = 100 - bias;
            run_left = $urandom_range(6, 2 * tracker.usable() + 8);
         end
         run_left--;
         r = $urandom_range(0, 99);
         if (r < 3) op = OP_CLEAR;
         else if (r < 10) op = OP_QUERY;
         else if ($urandom_range(0, 99) < bias) op = OP_ENQUEUE;
         else op = OP_DEQUEUE;
         send_word(op, $urandom());
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      send_word(OP_QUERY, 32'h0);
      send_word(OP_DEQUEUE, 32'hFFFF_FFFF);
      send_word(OP_ENQUEUE, 32'h0000_0000);
      send_word(OP_ENQUEUE, 32'hFFFF_FFFF);
      send_word(OP_ENQUEUE, 32'hA5A5_5A5A);
      repeat (3) send_word(OP_DEQUEUE, 32'h0);
      // shrink below the pointers without a clear: the advance wraps to zero
      write_capacity(5'd2);
      send_word(OP_ENQUEUE, 32'h1234_5678);
      send_word(OP_ENQUEUE, 32'h8765_4321);
      send_word(OP_ENQUEUE, 32'hDEAD_BEEF);
      repeat (3) send_word(OP_DEQUEUE, 32'h0);
      write_capacity(5'd4);
      send_word(OP_CLEAR, 32'h0);
      repeat (3) send_word(OP_ENQUEUE, $urandom());
      // shrink below the count: pushes refused, pops still drain
      write_capacity(5'd1);
      send_word(OP_ENQUEUE, 32'h5555_AAAA);
      send_word(OP_QUERY, 32'h0);
      repeat (3) send_word(OP_DEQUEUE, 32'h0);
      send_word(OP_CLEAR, 32'h0);

      run_phase(150, 5'd16, 0, 0, 1'b1);
      run_phase(140, 5'd1, 75, 0, 1'b1);
      run_phase(140, 5'd0, 0, 75, 1'b0);
      run_phase(150, 5'd31, 13, 13, 1'b1);
      run_phase(150, 5'd5, 0, 0, 1'b0);
      run_phase(140, 5'd17, 75, 0, 1'b1);
      run_phase(140, 5'd3, 0, 75, 1'b0);
      run_phase(150, 5'($urandom_range(1, 16)), 13, 13, 1'b1);

      drain();
      stall_pct = 0;
      repeat (8) @(posedge clock);
      if (tracker.outstanding() > 0) begin
         tracker.errors++;
         $display("%0t: %0d replies never arrived", $time, tracker.outstanding());
      end
      $display("Sent %0d words, checked %0d replies over capacities 0..31 and four idle mixes",
               tracker.requests, tracker.checked);
      $display("Refused pushes %0d, pops on empty %0d, clears %0d, mismatches %0d",
               tracker.refused, tracker.underflows, tracker.clears, tracker.errors);
      if (tracker.errors == 0)
         $display("circular_fifo_queue_core test passed");
      else
         $display("circular_fifo_queue_core test failed");
      $finish;
   end

endmodule
